@@ rtl/sbda_pkg.sv @@
// Shared constants, types and helpers for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

package sbda_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

    function automatic int num_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

@@ rtl/sbda_front.sv @@
// Front end: accept a number, split it into sign and unsigned magnitude.
`timescale 1ns / 1ps

module sbda_front #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  logic                  q_full,
    output logic                  q_push,
    output logic                  q_neg,
    output logic [VALUE_BITS-1:0] q_mag
);

    assign src_stall = q_full;
    assign q_push    = src_valid && !q_full;
    assign q_neg     = value[VALUE_BITS-1];
    assign q_mag     = q_neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

endmodule

@@ rtl/sbda_queue.sv @@
// Two-entry queue of sign and magnitude between front end and back end.
`timescale 1ns / 1ps

module sbda_queue #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  push_neg,
    input  logic [VALUE_BITS-1:0] push_mag,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output logic                  q_neg,
    output logic [VALUE_BITS-1:0] q_mag
);

    localparam int CNT_W = $clog2(sbda_pkg::QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(sbda_pkg::QUEUE_DEPTH);

    logic                  neg_mem_reg [sbda_pkg::QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] mag_mem_reg [sbda_pkg::QUEUE_DEPTH];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == CNT_W'(sbda_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_neg   = neg_mem_reg[rd_ptr_reg];
    assign q_mag   = mag_mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            neg_mem_reg[wr_ptr_reg] <= push_neg;
            mag_mem_reg[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

@@ rtl/sbda_back.sv @@
// Back end: bit-serial binary to BCD conversion, then character emission.
`timescale 1ns / 1ps

module sbda_back #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic                  q_neg,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  q_pop,
    output logic [7:0]            character,
    output logic                  last,
    output logic                  dst_valid,
    input  logic                  dst_stall
);

    localparam int NDIG   = sbda_pkg::num_digits(VALUE_BITS);
    localparam int BCD_W  = NDIG * 4;
    localparam int BIT_CW = $clog2(VALUE_BITS);
    localparam int DIG_CW = $clog2(NDIG);

    sbda_pkg::back_state_t state_reg;
    sbda_pkg::back_state_t state_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BIT_CW-1:0]     bit_cnt_reg;
    logic [BIT_CW-1:0]     bit_cnt_next;
    logic [DIG_CW-1:0]     dig_cnt_reg;
    logic [DIG_CW-1:0]     dig_cnt_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  started_reg;
    logic                  started_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  load_ok;
    logic [3:0]            top_digit;

    assign character = char_reg;
    assign last      = last_reg;
    assign dst_valid = out_valid_reg;
    assign load_ok   = !out_valid_reg || !dst_stall;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= sbda_pkg::BCD_ADJ_MIN)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + sbda_pkg::BCD_ADJ_ADD;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && dst_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            sbda_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    mag_next     = q_mag;
                    neg_next     = q_neg;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_BITS - 1);
                    state_next   = sbda_pkg::BK_CONV;
                end
            end
            sbda_pkg::BK_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CW'(NDIG - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? sbda_pkg::BK_SIGN : sbda_pkg::BK_DIGIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
                end
            end
            sbda_pkg::BK_SIGN:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sbda_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = sbda_pkg::BK_DIGIT;
                end
            end
            sbda_pkg::BK_DIGIT:
            begin
                if (top_digit == 4'd0 && !started_reg && dig_cnt_reg != '0)
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sbda_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_next      = (dig_cnt_reg == '0);
                    started_next   = 1'b1;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = sbda_pkg::BK_IDLE;
                    end
                    else
                    begin
                        dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = sbda_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbda_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

@@ rtl/signed_binary_to_decimal_ascii.sv @@
// Top level: signed binary number in, decimal ASCII characters out.
//
// Usage:
//   Input channel: value with src_valid / src_stall. A beat moves when
//   src_valid is high and src_stall low. Only the low VALUE_BITS bits count.
//   Output channel: character and last with dst_valid / dst_stall. One beat
//   per character: '-' first for a negative number, then the digits most
//   significant first without leading zeros; last marks the final digit.
//   A zero input gives the single character '0'.
//   Operation: the converter pops a queued number when it is idle, shifts
//   the magnitude through a BCD register one bit per cycle, then scans
//   the digit positions, emitting a character or skipping a leading zero
//   at each, after a minus sign for a negative number. It takes the next
//   number only once the last character of the previous one is issued.
//   The queue takes up to two further numbers while one is converted.
//   Reset empties the queue, returns the converter to idle and drops any
//   pending output beat. When the receiver stalls, the output beat holds
//   and no new character is issued; the queue keeps accepting until full.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  src_valid,
    output logic                  src_stall,
    output logic [7:0]            character,
    output logic                  last,
    output logic                  dst_valid,
    input  logic                  dst_stall
);

    logic                  q_full;
    logic                  q_push;
    logic                  push_neg;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  q_valid;
    logic                  q_pop;
    logic                  q_neg;
    logic [VALUE_BITS-1:0] q_mag;

    sbda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .value     (value),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_neg     (push_neg),
        .q_mag     (push_mag)
    );

    sbda_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_neg (push_neg),
        .push_mag (push_mag),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_neg    (q_neg),
        .q_mag    (q_mag)
    );

    sbda_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_neg     (q_neg),
        .q_mag     (q_mag),
        .q_pop     (q_pop),
        .character (character),
        .last      (last),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall)
    );

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (character == sbda_pkg::CHAR_MINUS)
            || (character >= sbda_pkg::CHAR_ZERO && character <= 8'd57))
        else $error("output character is neither minus nor digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && character == sbda_pkg::CHAR_MINUS |-> !last)
        else $error("minus sign flagged as last character");

    a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_valid)
        else $error("queue full but reports no data");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("converter popped an empty queue");

endmodule

@@ tb/sbda_checker.sv @@
// Checker for the decimal ASCII converter: predicts the text of each number and compares beats.
`timescale 1ns / 1ps

module sbda_checker #(
    parameter int BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [BITS-1:0] value,
    input  logic            src_valid,
    input  logic            src_stall,
    input  logic [7:0]      character,
    input  logic            last,
    input  logic            dst_valid,
    input  logic            dst_stall,
    output int              mismatches,
    output int              outstanding
);

    typedef struct packed {
        logic [7:0] code;
        logic       tail;
    } text_char_t;

    text_char_t expected_text[$];
    int         mismatch_count = 0;
    int         pending_count  = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic spell_number(input logic [BITS-1:0] number);
        logic             negative;
        logic [BITS-1:0]  magnitude;
        logic [7:0]       digit_stack[$];
        text_char_t       beat;
        negative  = number[BITS-1];
        magnitude = negative ? (~number + 1'b1) : number;
        if (magnitude == '0)
        begin
            digit_stack.push_front(8'd0);
        end
        while (magnitude != '0)
        begin
            digit_stack.push_front(8'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        if (negative)
        begin
            beat.code = sbda_pkg::CHAR_MINUS;
            beat.tail = 1'b0;
            expected_text.push_back(beat);
        end
        foreach (digit_stack[i])
        begin
            beat.code = sbda_pkg::CHAR_ZERO + digit_stack[i];
            beat.tail = (i == digit_stack.size() - 1);
            expected_text.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            expected_text.delete();
            pending_count = 0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat character=%0d last=%0b",
                                            character, last));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.code)
                        flag_mismatch($sformatf("character got %0d want %0d",
                                                character, want.code));
                    if (last !== want.tail)
                        flag_mismatch($sformatf("last got %0b want %0b (character %0d)",
                                                last, want.tail, want.code));
                end
            end
            if (src_valid && !src_stall)
                spell_number(value);
            pending_count = expected_text.size();
        end
    end

endmodule

@@ tb/tb_signed_binary_to_decimal_ascii.sv @@
// Testbench top for the decimal ASCII converter: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_signed_binary_to_decimal_ascii;

    localparam int BITS = sbda_pkg::VALUE_BITS_DEFAULT;
    localparam int RANDOM_NUMBERS = 292;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic [BITS-1:0] value = '0;
    logic            src_valid = 1'b0;
    logic            src_stall;
    logic [7:0]      character;
    logic            last;
    logic            dst_valid;
    logic            dst_stall = 1'b0;
    int              mismatches;
    int              outstanding;
    bit              quiet = 1'b0;

    signed_binary_to_decimal_ascii #(
        .VALUE_BITS(BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .character (character),
        .last      (last),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall)
    );

    sbda_checker #(
        .BITS(BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .character   (character),
        .last        (last),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    function automatic int pick_wait();
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [31:0] draw_number();
        longint unsigned lo;
        longint unsigned hi;
        logic [31:0]     n;
        int              k;
        case ($urandom_range(0, 7))
            0, 1, 2, 3:
            begin
                n = $urandom;
            end
            4, 5:
            begin
                k  = $urandom_range(1, 10);
                lo = 1;
                repeat (k - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'd2147483648)
                    hi = 64'd2147483648;
                n = $urandom_range(32'(hi), 32'(lo));
            end
            6:
            begin
                k = $urandom_range(0, 9);
                n = 1;
                repeat (k) n = n * 10;
                if ($urandom_range(0, 1))
                    n = n - 1;
            end
            default:
            begin
                n = $urandom_range(0, 20);
            end
        endcase
        if ($urandom_range(0, 1))
            n = -n;
        return n;
    endfunction

    task automatic send_number(input logic [BITS-1:0] number);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        value     <= number;
        do @(posedge clk); while (src_stall);
    endtask

    task automatic drain_text();
        src_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     -32'sd99, 32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000,
                     -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h8000_0001, -32'sd7};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_number(directed[i]);
        drain_text();
        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_NUMBERS / 2)
                drain_text();
            send_number(draw_number());
        end
        drain_text();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = pick_wait();
            if (hold > 0)
            begin
                dst_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            dst_stall <= 1'b0;
            do @(posedge clk); while (!dst_valid);
        end
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ signed_binary_to_decimal_ascii.f @@
rtl/sbda_pkg.sv
rtl/sbda_front.sv
rtl/sbda_queue.sv
rtl/sbda_back.sv
rtl/signed_binary_to_decimal_ascii.sv
tb/sbda_checker.sv
tb/tb_signed_binary_to_decimal_ascii.sv
